// ===== sv/atpt_pkg.sv =====
`default_nettype none

package atpt_pkg;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_ENTER = 2'd1,
        EV_STAY  = 2'd2,
        EV_EXIT  = 2'd3
    } t_event;

    typedef enum logic {
        CMD_CHECK = 1'b0,
        CMD_CLEAR = 1'b1
    } t_cmd;

    localparam int unsigned KEY_W = 64;

    typedef struct packed {
        logic               command;
        logic [31:0]        first_id;
        logic [31:0]        second_id;
        logic signed [15:0] first_center_x;
        logic signed [15:0] first_center_y;
        logic [14:0]        first_width;
        logic [14:0]        first_height;
        logic signed [15:0] second_center_x;
        logic signed [15:0] second_center_y;
        logic [14:0]        second_width;
        logic [14:0]        second_height;
        logic               either_destroyed;
    } t_in_item;

    typedef struct packed {
        logic [1:0] event_res;
        logic       table_full;
    } t_out_item;

    // Request travelling along the cell chain
    typedef struct packed {
        logic             vld;
        logic             clr;
        logic             done;
        logic             hit;
        t_event           ev;
        logic [KEY_W-1:0] key;
    } t_tok;

endpackage

`default_nettype wire

// ===== sv/aabb_trigger_pair_tracker.sv =====
`default_nettype none

// Tracks trigger contact between ordered collider pairs. Each request either
// clears the pair table or tests two boxes for overlap and returns enter,
// stay, exit or none for that pair, or table_full when a new pair finds no
// room. The table is a chain of PAIR_ENTRIES cells, one entry per cell, and
// a request walks one cell per cycle, passing the front register, every cell
// and the output register. Requests follow each other through the chain,
// one accepted per cycle. A stall on the output freezes the whole chain.
module aabb_trigger_pair_tracker #(
    parameter int unsigned PAIR_ENTRIES = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire atpt_pkg::t_in_item i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output atpt_pkg::t_out_item     o_out_item
);
    import atpt_pkg::*;

    logic      w_adv;
    t_tok      w_tok [PAIR_ENTRIES+1];
    t_tok      w_tail;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item n_out_item;

    assign w_adv      = ~r_out_valid | i_out_ready;
    assign o_in_ready = w_adv;

    atpt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (i_in_valid),
        .i_item  (i_in_item),
        .o_tok   (w_tok[0])
    );

    for (genvar g = 0; g < PAIR_ENTRIES; g++) begin : g_cell
        atpt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign w_tail = w_tok[PAIR_ENTRIES];

    // A check request that no cell took means the table is full
    always_comb begin
        n_out_item.event_res  = w_tail.done ? w_tail.ev : EV_NONE;
        n_out_item.table_full = ~w_tail.clr & ~w_tail.done;
        if (w_tail.clr) begin
            n_out_item.event_res = EV_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_tail.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// ===== sv/atpt_front.sv =====
`default_nettype none

module atpt_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_adv,
    input  wire logic             i_vld,
    input  wire atpt_pkg::t_in_item i_item,
    output atpt_pkg::t_tok        o_tok
);
    import atpt_pkg::*;

    t_tok r_tok;
    t_tok n_tok;

    // 2*|c1-c2| <= s1+s2, exact
    function automatic logic axis_ok(input logic signed [15:0] c1,
                                     input logic signed [15:0] c2,
                                     input logic [14:0] s1,
                                     input logic [14:0] s2);
        logic signed [16:0] d;
        logic [16:0]        m;
        logic [15:0]        sum;
        d   = 17'(c1) - 17'(c2);
        m   = d[16] ? 17'(-d) : 17'(d);
        sum = {1'b0, s1} + {1'b0, s2};
        return {m[15:0], 1'b0} <= {1'b0, sum};
    endfunction

    always_comb begin
        n_tok      = r_tok;
        n_tok.vld  = i_vld;
        n_tok.clr  = (i_item.command == CMD_CLEAR);
        n_tok.done = 1'b0;
        n_tok.ev   = EV_NONE;
        n_tok.key  = {i_item.second_id, i_item.first_id};
        n_tok.hit  = axis_ok(i_item.first_center_x, i_item.second_center_x,
                             i_item.first_width, i_item.second_width)
                   & axis_ok(i_item.first_center_y, i_item.second_center_y,
                             i_item.first_height, i_item.second_height)
                   & ~i_item.either_destroyed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

// ===== sv/atpt_cell.sv =====
`default_nettype none

module atpt_cell (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_adv,
    input  wire atpt_pkg::t_tok i_tok,
    output atpt_pkg::t_tok    o_tok
);
    import atpt_pkg::*;

    logic             r_valid;
    logic             r_touch;
    logic [KEY_W-1:0] r_key;
    t_tok             r_tok;

    logic             n_valid;
    logic             n_touch;
    logic [KEY_W-1:0] n_key;
    t_tok             n_tok;

    // Valid entries always form a prefix of the chain, so the first empty
    // cell proves the key is absent further on.
    always_comb begin
        n_valid = r_valid;
        n_touch = r_touch;
        n_key   = r_key;
        n_tok   = i_tok;
        if (i_tok.vld && i_tok.clr) begin
            n_valid = 1'b0;
            n_touch = 1'b0;
        end else if (i_tok.vld && !i_tok.done) begin
            if (r_valid && r_key == i_tok.key) begin
                n_tok.done = 1'b1;
                if (r_touch) begin
                    n_tok.ev = i_tok.hit ? EV_STAY : EV_EXIT;
                    n_touch  = i_tok.hit;
                end else begin
                    n_tok.ev = i_tok.hit ? EV_ENTER : EV_NONE;
                    n_touch  = i_tok.hit;
                end
            end else if (!r_valid) begin
                n_tok.done = 1'b1;
                n_tok.ev   = i_tok.hit ? EV_ENTER : EV_NONE;
                n_valid    = 1'b1;
                n_touch    = i_tok.hit;
                n_key      = i_tok.key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_touch   <= 1'b0;
            r_tok.vld <= 1'b0;
        end else if (i_adv) begin
            r_valid <= n_valid;
            r_touch <= n_touch;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_key <= n_key;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

// ===== dv/tb_aabb_trigger_pair_tracker.sv =====
module tb_aabb_trigger_pair_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    import atpt_pkg::*;

    localparam int ENTRIES     = 64;
    localparam int N_ITEMS     = 1950;
    localparam int CYCLE_LIMIT = 200000;

    typedef enum {GEO_OVERLAP, GEO_EDGE, GEO_APART} t_geo;

    logic      i_clk    = 1'b0;
    logic      i_rst_n  = 1'b0;
    logic      in_valid = 1'b0;
    logic      out_ready = 1'b0;
    t_in_item  in_item  = '0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_item;

    // Mirror of the pair table
    logic [63:0] pair_keys [ENTRIES];
    bit          pair_used [ENTRIES];
    bit          pair_touch [ENTRIES];

    t_in_item    item_q [$];
    t_out_item   outcome_q [$];
    logic [31:0] id_pool [12];
    int          pool_n     = 12;
    int          n_errors   = 0;
    int          n_results  = 0;
    int          cycles     = 0;
    bit          in_fire    = 1'b0;
    int          burst_left = 1;
    int          gap_left   = 0;
    int          rx_mode    = 0;
    int          mode_left  = 0;
    int          hold_left  = 0;
    bit          hold_done  = 1'b0;

    aabb_trigger_pair_tracker #(
        .PAIR_ENTRIES(ENTRIES)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_item (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit axis_hits(input logic signed [15:0] c1, c2,
                                     input logic [14:0] s1, s2);
        int d;
        d = int'(c1) - int'(c2);
        if (d < 0) d = -d;
        return 2 * d <= int'(s1) + int'(s2);
    endfunction

    function automatic t_out_item track_contact(input t_in_item it);
        t_out_item   res;
        logic [63:0] key;
        int          slot;
        int          free_slot;
        bit          overlap;
        res.event_res  = EV_NONE;
        res.table_full = 1'b0;
        if (it.command == CMD_CLEAR) begin
            for (int i = 0; i < ENTRIES; i++) begin
                pair_used[i]  = 1'b0;
                pair_touch[i] = 1'b0;
            end
            return res;
        end
        key       = {it.second_id, it.first_id};
        slot      = -1;
        free_slot = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (pair_used[i]) begin
                if (slot < 0 && pair_keys[i] == key) slot = i;
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        if (slot < 0) begin
            if (free_slot < 0) begin
                res.table_full = 1'b1;
                return res;
            end
            slot             = free_slot;
            pair_keys[slot]  = key;
            pair_used[slot]  = 1'b1;
            pair_touch[slot] = 1'b0;
        end
        overlap = axis_hits(it.first_center_x, it.second_center_x,
                            it.first_width, it.second_width) &&
                  axis_hits(it.first_center_y, it.second_center_y,
                            it.first_height, it.second_height) &&
                  !it.either_destroyed;
        if (pair_touch[slot]) begin
            res.event_res = overlap ? EV_STAY : EV_EXIT;
            pair_touch[slot] = overlap;
        end else if (overlap) begin
            res.event_res    = EV_ENTER;
            pair_touch[slot] = 1'b1;
        end
        return res;
    endfunction

    task automatic add_clear(input bit all_ones);
        t_in_item    it;
        logic [191:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it  = all_ones ? '1 : t_in_item'(raw[$bits(t_in_item)-1:0]);
        it.command = CMD_CLEAR;
        item_q.push_back(it);
    endtask

    task automatic add_boxes(input logic [31:0] a, b,
                             input int c1x, c1y, w1, h1, c2x, c2y, w2, h2,
                             input bit gone);
        t_in_item it;
        it = '0;
        it.command          = CMD_CHECK;
        it.first_id         = a;
        it.second_id        = b;
        it.first_center_x   = 16'(c1x);
        it.first_center_y   = 16'(c1y);
        it.first_width      = 15'(w1);
        it.first_height     = 15'(h1);
        it.second_center_x  = 16'(c2x);
        it.second_center_y  = 16'(c2y);
        it.second_width     = 15'(w2);
        it.second_height    = 15'(h2);
        it.either_destroyed = gone;
        item_q.push_back(it);
    endtask

    // Place two extents along one axis, near the touching limit in edge mode
    task automatic gen_axis(input t_geo mode, output logic signed [15:0] c1, c2,
                            output logic [14:0] s1, s2);
        int sum;
        int mag;
        int base;
        s1 = ($urandom_range(0, 3) == 0) ? 15'($urandom_range(0, 32767))
                                         : 15'($urandom_range(0, 300));
        s2 = ($urandom_range(0, 3) == 0) ? 15'($urandom_range(0, 32767))
                                         : 15'($urandom_range(0, 300));
        sum  = int'(s1) + int'(s2);
        base = $urandom_range(0, 65535) - 32768;
        case (mode)
            GEO_OVERLAP: mag = $urandom_range(0, sum / 2);
            GEO_EDGE:    mag = sum / 2 + $urandom_range(0, 1);
            default:     mag = sum / 2 + 1 + $urandom_range(0, 2000);
        endcase
        if ($urandom_range(0, 1) == 1) mag = -mag;
        c1 = 16'(base);
        c2 = 16'(base - mag);
    endtask

    task automatic add_pair(input logic [31:0] a, b, input t_geo gx, gy);
        t_in_item it;
        it = '0;
        it.command   = CMD_CHECK;
        it.first_id  = a;
        it.second_id = b;
        gen_axis(gx, it.first_center_x, it.second_center_x,
                 it.first_width, it.second_width);
        gen_axis(gy, it.first_center_y, it.second_center_y,
                 it.first_height, it.second_height);
        it.either_destroyed = ($urandom_range(0, 9) == 0);
        item_q.push_back(it);
    endtask

    task automatic refill_pool();
        pool_n = $urandom_range(3, 12);
        foreach (id_pool[i]) id_pool[i] = $urandom;
    endtask

    task automatic build_stimulus();
        t_in_item     it;
        logic [191:0] raw;
        logic [31:0]  a;
        logic [31:0]  b;
        int           pick;
        int           sel;
        // Directed: extremes, every event, touching limits, clear
        add_clear(1'b1);
        add_boxes(0, 0, -32768, -32768, 32767, 32767,
                  -32768, -32768, 32767, 32767, 1'b0);
        add_boxes(0, 0, -32768, -32768, 32767, 32767,
                  -32768, -32768, 32767, 32767, 1'b0);
        add_boxes(0, 0, -32768, -32768, 32767, 32767,
                  -32768, -32768, 32767, 32767, 1'b1);
        add_boxes(0, 0, -32768, -32768, 32767, 32767,
                  -32768, -32768, 32767, 32767, 1'b1);
        add_boxes(0, 0, 0, 0, 5, 5, 0, 0, 5, 5, 1'b0);
        add_boxes(0, 0, 0, 0, 0, 0, 100, 0, 0, 0, 1'b0);
        add_boxes('1, '1, 32767, 32767, 32767, 32767,
                  -32768, -32768, 32767, 32767, 1'b1);
        add_boxes(1, 2, 0, 0, 10, 10, 10, 0, 10, 10, 1'b0);
        add_boxes(2, 1, 0, 0, 10, 10, 11, 0, 10, 10, 1'b0);
        add_boxes(1, 2, 0, 0, 10, 10, 0, -11, 10, 10, 1'b0);
        add_boxes(3, 4, 5, 5, 0, 0, 5, 5, 0, 0, 1'b0);
        add_boxes(3, 4, 5, 5, 0, 0, 5, 6, 0, 0, 1'b0);
        add_boxes(3, 4, -1, -1, 1, 1, 0, 0, 1, 1, 1'b0);
        add_clear(1'b0);
        add_boxes(1, 2, 0, 0, 10, 10, 0, 0, 10, 10, 1'b0);

        // Random: runs on pooled pairs so the table fills, plus noise and clears
        refill_pool();
        while (item_q.size() < N_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 1) begin
                add_clear(1'b0);
                refill_pool();
            end else if (pick < 9) begin
                raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
                it  = t_in_item'(raw[$bits(t_in_item)-1:0]);
                it.command = CMD_CHECK;
                item_q.push_back(it);
            end else begin
                a = id_pool[$urandom_range(0, pool_n - 1)];
                b = id_pool[$urandom_range(0, pool_n - 1)];
                repeat ($urandom_range(1, 5)) begin
                    sel = $urandom_range(0, 9);
                    if (sel < 6)      add_pair(a, b, GEO_OVERLAP, GEO_OVERLAP);
                    else if (sel < 7) add_pair(a, b, GEO_EDGE, GEO_OVERLAP);
                    else if (sel < 8) add_pair(a, b, GEO_OVERLAP, GEO_EDGE);
                    else if (sel < 9) add_pair(a, b, GEO_APART, GEO_OVERLAP);
                    else              add_pair(a, b, GEO_OVERLAP, GEO_APART);
                end
            end
        end
    endtask

    // Sender: bursts of requests separated by random gaps
    always @(negedge i_clk) begin
        if (i_rst_n && !(in_valid && !in_fire)) begin
            in_fire = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (item_q.size() != 0) begin
                in_item  <= item_q.pop_front();
                in_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 30);
                    gap_left   = $urandom_range(1, 10);
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern changes mode at random intervals
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!hold_done && n_results >= 300) begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 120);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= (cycles % 4 == 0);
                    default: out_ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // Predict on each accepted request, then check each accepted result
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (in_valid && o_in_ready) begin
                outcome_q.push_back(track_contact(in_item));
                in_fire = 1'b1;
            end
            if (o_out_valid && out_ready) begin
                n_results++;
                if (outcome_q.size() == 0) begin
                    $error("unexpected result: event_res %0d table_full %0d",
                           o_out_item.event_res, o_out_item.table_full);
                    n_errors++;
                end else begin
                    want = outcome_q.pop_front();
                    if (o_out_item.event_res !== want.event_res) begin
                        $error("event_res: expected %0d, got %0d",
                               want.event_res, o_out_item.event_res);
                        n_errors++;
                    end
                    if (o_out_item.table_full !== want.table_full) begin
                        $error("table_full: expected %0d, got %0d",
                               want.table_full, o_out_item.table_full);
                        n_errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        foreach (pair_used[i]) begin
            pair_used[i]  = 1'b0;
            pair_touch[i] = 1'b0;
        end
        build_stimulus();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (item_q.size() != 0 || in_valid) @(posedge i_clk);
        while (outcome_q.size() != 0) @(posedge i_clk);
        // Drain: catch any stray result behind the last one
        repeat (ENTRIES + 20) @(posedge i_clk);
        if (n_errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
sv/atpt_pkg.sv
sv/atpt_front.sv
sv/atpt_cell.sv
sv/aabb_trigger_pair_tracker.sv
dv/tb_aabb_trigger_pair_tracker.sv
